>>> rtl/core/pis_pkg.sv
// Shared constants, widths, latencies and types for the projectile intercept solver.
// No dependencies; every other file imports this package.
`default_nettype none

package pis_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int MIN_TIME_LSB  = 7;
    localparam int NEAR_ZERO_LSB = 0;

    localparam int COORD_W = 32;
    localparam int SPEED_W = 31;
    localparam int P_W     = 33;
    localparam int SQ_W    = 66;
    localparam int SS_W    = 62;
    localparam int COEF_W  = 68;
    localparam int MAG_W   = 66;
    localparam int HALF_W  = 33;
    localparam int PART_W  = 2 * HALF_W;
    localparam int PROD_W  = 132;
    localparam int D_W     = 134;
    localparam int RAD_W   = D_W;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 3;
    localparam int NUM_W   = 68;
    localparam int DEN_W   = COEF_W - 1;
    localparam int Q_W     = 31;
    localparam int PR_W    = 64;

    localparam int FRONT_LAT  = 7;
    localparam int SQRT_LAT   = ROOT_W;
    localparam int PREP_LAT   = 1;
    localparam int DIV_LAT    = Q_W + 2;
    localparam int MERGE_LAT  = 3;
    localparam int SIDE_DEPTH = FRONT_LAT + SQRT_LAT + PREP_LAT + DIV_LAT;
    localparam int PIPE_LAT   = SIDE_DEPTH + MERGE_LAT;

    localparam logic signed [COORD_W-1:0] FAIL_TIME = -(COORD_W'(1) << FRAC_BITS);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef coord_t [2:0] vec3_t;

    typedef struct packed {
        logic  spd_nz;
        vec3_t tp;
        vec3_t tv;
    } side_t;

    typedef struct packed {
        logic                     lin;
        logic                     lin_ok;
        logic                     dneg;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] h;
        logic [MAG_W-1:0]         c;
    } qside_t;

    typedef struct packed {
        logic   found;
        coord_t t;
        coord_t x;
        coord_t y;
        coord_t z;
    } res_t;

endpackage

`default_nettype wire

>>> rtl/core/pis_in_if.sv
// Input item channel: valid/ready handshake with shooter and target state.
// Depends on pis_pkg for the coordinate width.
`default_nettype none

interface pis_in_if
    import pis_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] shooter_px;
    logic signed [COORD_W-1:0] shooter_py;
    logic signed [COORD_W-1:0] shooter_pz;
    logic signed [COORD_W-1:0] shooter_vx;
    logic signed [COORD_W-1:0] shooter_vy;
    logic signed [COORD_W-1:0] shooter_vz;
    logic signed [COORD_W-1:0] target_px;
    logic signed [COORD_W-1:0] target_py;
    logic signed [COORD_W-1:0] target_pz;
    logic signed [COORD_W-1:0] target_vx;
    logic signed [COORD_W-1:0] target_vy;
    logic signed [COORD_W-1:0] target_vz;

    modport source (
        output valid, shooter_px, shooter_py, shooter_pz, shooter_vx, shooter_vy, shooter_vz,
        output target_px, target_py, target_pz, target_vx, target_vy, target_vz,
        input  ready
    );

    modport sink (
        input  valid, shooter_px, shooter_py, shooter_pz, shooter_vx, shooter_vy, shooter_vz,
        input  target_px, target_py, target_pz, target_vx, target_vy, target_vz,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/pis_out_if.sv
// Result item channel: valid/ready handshake with intercept flag, time and point.
// Depends on pis_pkg for the coordinate width.
`default_nettype none

interface pis_out_if
    import pis_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic                      found;
    logic signed [COORD_W-1:0] intercept_time;
    logic signed [COORD_W-1:0] intercept_x;
    logic signed [COORD_W-1:0] intercept_y;
    logic signed [COORD_W-1:0] intercept_z;

    modport source (
        output valid, found, intercept_time, intercept_x, intercept_y, intercept_z,
        input  ready
    );

    modport sink (
        input  valid, found, intercept_time, intercept_x, intercept_y, intercept_z,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/projectile_intercept_solver.sv
// Top level of the projectile intercept solver: config register, pipeline, output skid.
// Depends on pis_pkg, pis_in_if, pis_out_if, pis_front, pis_sqrt, pis_div, pis_merge.
//
//  channel   dir  handshake          payload
//  query     in   valid/ready        shooter and target position, velocity (12 x Q16.16)
//  answer    out  valid/ready        found, intercept_time, intercept_x/y/z
//  cfg       in   cfg_wr_en          cfg_wr_data: projectile speed, unsigned Q15.16
//
// One item per cycle sustained while the skid register is empty; the depth comes from the 67-stage square root
// and the two 33-stage divide lanes that run side by side.
// rst_n clears the valid line, the output and skid flags and the speed register.
// A stall on answer fills the skid register; the whole pipeline then holds until it drains.
`default_nettype none

module projectile_intercept_solver
    import pis_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [SPEED_W-1:0] cfg_wr_data,
    pis_in_if.sink                  query,
    pis_out_if.source               answer
);

    logic [SPEED_W-1:0]       speed_reg;
    logic                     vld_reg [PIPE_LAT];
    side_t                    side_reg [SIDE_DEPTH];
    logic                     pipe_en;

    vec3_t                    s_p, s_v, t_p, t_v;
    side_t                    side_in;
    logic [RAD_W-1:0]         rad;
    qside_t                   fq, sq;
    logic [ROOT_W-1:0]        root;

    logic signed [NUM_W:0]    num1_reg, num2_reg, num1_next, num2_next;
    logic signed [DEN_W:0]    den1_reg, den2_reg, den1_next, den2_next;
    logic                     use1_reg, use2_reg, use1_next, use2_next;
    logic [Q_W-1:0]           t1, t2;
    res_t                     pipe_res;

    res_t                     out_reg, skid_reg;
    logic                     out_vld_reg, skid_full_reg;

    assign pipe_en     = !skid_full_reg;
    assign query.ready = pipe_en;

    assign s_p = {query.shooter_pz, query.shooter_py, query.shooter_px};
    assign s_v = {query.shooter_vz, query.shooter_vy, query.shooter_vx};
    assign t_p = {query.target_pz, query.target_py, query.target_px};
    assign t_v = {query.target_vz, query.target_vy, query.target_vx};

    always_comb
    begin
        side_in.spd_nz = speed_reg != '0;
        side_in.tp     = t_p;
        side_in.tv     = t_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            speed_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PIPE_LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (pipe_en)
        begin
            vld_reg[0] <= query.valid;
            for (int k = 1; k < PIPE_LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            side_reg[0] <= side_in;
            for (int k = 1; k < SIDE_DEPTH; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    pis_front u_front (
        .clk   (clk),
        .en    (pipe_en),
        .s_p   (s_p),
        .s_v   (s_v),
        .t_p   (t_p),
        .t_v   (t_v),
        .speed (speed_reg),
        .rad   (rad),
        .side  (fq)
    );

    pis_sqrt u_sqrt (
        .clk      (clk),
        .en       (pipe_en),
        .rad      (rad),
        .side_in  (fq),
        .root     (root),
        .side_out (sq)
    );

    // dispatch the linear case to lane one, the two quadratic roots to both lanes
    always_comb
    begin
        logic signed [NUM_W:0] h_ext;
        logic signed [NUM_W:0] r_ext;
        h_ext = {sq.h[COEF_W-1], sq.h};
        r_ext = (NUM_W + 1)'(root);
        if (sq.lin)
        begin
            num1_next = (NUM_W + 1)'(sq.c);
            den1_next = COEF_W'(0) - {sq.h[COEF_W-2:0], 1'b0};
            use1_next = sq.lin_ok;
            num2_next = '0;
            den2_next = sq.a;
            use2_next = 1'b0;
        end
        else
        begin
            num1_next = r_ext - h_ext;
            den1_next = sq.a;
            use1_next = !sq.dneg;
            num2_next = (NUM_W + 1)'(0) - h_ext - r_ext;
            den2_next = sq.a;
            use2_next = !sq.dneg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            num1_reg <= num1_next;
            num2_reg <= num2_next;
            den1_reg <= den1_next;
            den2_reg <= den2_next;
            use1_reg <= use1_next;
            use2_reg <= use2_next;
        end
    end

    pis_div u_div_lane1 (
        .clk      (clk),
        .en       (pipe_en),
        .use_lane (use1_reg),
        .num      (num1_reg),
        .den      (den1_reg),
        .t        (t1)
    );

    pis_div u_div_lane2 (
        .clk      (clk),
        .en       (pipe_en),
        .use_lane (use2_reg),
        .num      (num2_reg),
        .den      (den2_reg),
        .t        (t2)
    );

    pis_merge u_merge (
        .clk  (clk),
        .en   (pipe_en),
        .t1   (t1),
        .t2   (t2),
        .side (side_reg[SIDE_DEPTH-1]),
        .res  (pipe_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg   <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (!out_vld_reg || answer.ready)
        begin
            if (skid_full_reg)
            begin
                out_vld_reg   <= 1'b1;
                skid_full_reg <= 1'b0;
            end
            else
            begin
                out_vld_reg <= vld_reg[PIPE_LAT-1];
            end
        end
        else if (vld_reg[PIPE_LAT-1] && !skid_full_reg)
        begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || answer.ready)
        begin
            out_reg <= skid_full_reg ? skid_reg : pipe_res;
        end
        else if (!skid_full_reg)
        begin
            skid_reg <= pipe_res;
        end
    end

    assign answer.valid          = out_vld_reg;
    assign answer.found          = out_reg.found;
    assign answer.intercept_time = out_reg.t;
    assign answer.intercept_x    = out_reg.x;
    assign answer.intercept_y    = out_reg.y;
    assign answer.intercept_z    = out_reg.z;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_vld_reg)
        else $error("skid holds an item while output is empty");

    a_pipe_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[PIPE_LAT-1] && pipe_en) |=> out_vld_reg)
        else $error("item leaving pipeline was dropped");

    a_fail_time: assert property (@(posedge clk) disable iff (!rst_n)
        (answer.valid && !answer.found) |-> (answer.intercept_time == FAIL_TIME))
        else $error("failed item carries a time other than minus one");

    a_found_time: assert property (@(posedge clk) disable iff (!rst_n)
        (answer.valid && answer.found) |->
            (answer.intercept_time > $signed(COORD_W'(MIN_TIME_LSB))))
        else $error("found item carries a time at or below threshold");

endmodule

`default_nettype wire

>>> rtl/core/pis_front.sv
// Front end: relative state per axis lane, quadratic coefficients and discriminant.
// Seven register stages; wide products split into 33-bit partials. Uses pis_pkg.
`default_nettype none

module pis_front
    import pis_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire vec3_t             s_p,
    input  wire vec3_t             s_v,
    input  wire vec3_t             t_p,
    input  wire vec3_t             t_v,
    input  wire logic [SPEED_W-1:0] speed,
    output logic [RAD_W-1:0]       rad,
    output qside_t                 side
);

    logic signed [P_W-1:0]    p_reg [3];
    logic signed [P_W-1:0]    v_reg [3];
    logic signed [SQ_W-1:0]   pp_reg [3];
    logic signed [SQ_W-1:0]   vv_reg [3];
    logic signed [SQ_W-1:0]   pv_reg [3];
    logic [SS_W-1:0]          ss_reg;
    qside_t                   side2_reg, side3_reg, side4_reg, side5_reg, side6_reg;
    qside_t                   side2_next, side3_next, side6_next;
    logic [MAG_W-1:0]         amag_reg, hmag_reg;
    logic [MAG_W-1:0]         amag_next, hmag_next;
    logic [PART_W-1:0]        hh_reg, hl_reg, ll_reg, ahch_reg, ahcl_reg, alch_reg, alcl_reg;
    logic [PROD_W-1:0]        h2_reg, ac_reg, h2_next, ac_next;
    logic signed [D_W-1:0]    d_reg, d_next;

    always_comb
    begin
        side2_next = '0;
        side2_next.a = COEF_W'(vv_reg[0]) + COEF_W'(vv_reg[1]) + COEF_W'(vv_reg[2])
                     - $signed(COEF_W'(ss_reg));
        side2_next.h = COEF_W'(pv_reg[0]) + COEF_W'(pv_reg[1]) + COEF_W'(pv_reg[2]);
        side2_next.c = MAG_W'(pp_reg[0]) + MAG_W'(pp_reg[1]) + MAG_W'(pp_reg[2]);
    end

    always_comb
    begin
        amag_next = side2_reg.a[COEF_W-1] ? MAG_W'(-side2_reg.a) : MAG_W'(side2_reg.a);
        hmag_next = side2_reg.h[COEF_W-1] ? MAG_W'(-side2_reg.h) : MAG_W'(side2_reg.h);
        side3_next = side2_reg;
        side3_next.lin = amag_next <= MAG_W'(NEAR_ZERO_LSB);
        side3_next.lin_ok = {hmag_next, 1'b0} > (MAG_W + 1)'(NEAR_ZERO_LSB);
    end

    always_comb
    begin
        h2_next = (PROD_W'(hh_reg) << PART_W) + (PROD_W'(hl_reg) << (HALF_W + 1))
                + PROD_W'(ll_reg);
        ac_next = (PROD_W'(ahch_reg) << PART_W)
                + ((PROD_W'(ahcl_reg) + PROD_W'(alch_reg)) << HALF_W)
                + PROD_W'(alcl_reg);
    end

    always_comb
    begin
        if (side5_reg.a[COEF_W-1])
        begin
            d_next = $signed(D_W'(h2_reg) + D_W'(ac_reg));
        end
        else
        begin
            d_next = $signed(D_W'(h2_reg) - D_W'(ac_reg));
        end
        side6_next = side5_reg;
        side6_next.dneg = d_next[D_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p_reg[i]  <= $signed({t_p[i][COORD_W-1], t_p[i]})
                           - $signed({s_p[i][COORD_W-1], s_p[i]});
                v_reg[i]  <= $signed({t_v[i][COORD_W-1], t_v[i]})
                           - $signed({s_v[i][COORD_W-1], s_v[i]});
                pp_reg[i] <= SQ_W'(p_reg[i]) * SQ_W'(p_reg[i]);
                vv_reg[i] <= SQ_W'(v_reg[i]) * SQ_W'(v_reg[i]);
                pv_reg[i] <= SQ_W'(p_reg[i]) * SQ_W'(v_reg[i]);
            end
            ss_reg    <= SS_W'(speed) * SS_W'(speed);
            side2_reg <= side2_next;
            amag_reg  <= amag_next;
            hmag_reg  <= hmag_next;
            side3_reg <= side3_next;
            hh_reg    <= PART_W'(hmag_reg[MAG_W-1:HALF_W]) * PART_W'(hmag_reg[MAG_W-1:HALF_W]);
            hl_reg    <= PART_W'(hmag_reg[MAG_W-1:HALF_W]) * PART_W'(hmag_reg[HALF_W-1:0]);
            ll_reg    <= PART_W'(hmag_reg[HALF_W-1:0]) * PART_W'(hmag_reg[HALF_W-1:0]);
            ahch_reg  <= PART_W'(amag_reg[MAG_W-1:HALF_W])
                       * PART_W'(side3_reg.c[MAG_W-1:HALF_W]);
            ahcl_reg  <= PART_W'(amag_reg[MAG_W-1:HALF_W]) * PART_W'(side3_reg.c[HALF_W-1:0]);
            alch_reg  <= PART_W'(amag_reg[HALF_W-1:0]) * PART_W'(side3_reg.c[MAG_W-1:HALF_W]);
            alcl_reg  <= PART_W'(amag_reg[HALF_W-1:0]) * PART_W'(side3_reg.c[HALF_W-1:0]);
            side4_reg <= side3_reg;
            h2_reg    <= h2_next;
            ac_reg    <= ac_next;
            side5_reg <= side4_reg;
            d_reg     <= d_next;
            side6_reg <= side6_next;
        end
    end

    assign rad  = RAD_W'(d_reg);
    assign side = side6_reg;

endmodule

`default_nettype wire

>>> rtl/core/pis_sqrt.sv
// Pipelined integer square root of the discriminant, one root bit per stage.
// Carries the coefficient sideband alongside. Uses pis_pkg.
`default_nettype none

module pis_sqrt
    import pis_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [RAD_W-1:0] rad,
    input  wire qside_t           side_in,
    output logic [ROOT_W-1:0]     root,
    output qside_t                side_out
);

    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [RAD_W-1:0]  x_reg    [ROOT_W];
    qside_t            side_reg [ROOT_W];

    logic [REM_W-1:0]  rem_in   [ROOT_W];
    logic [ROOT_W-1:0] root_in  [ROOT_W];
    logic [RAD_W-1:0]  x_in     [ROOT_W];
    qside_t            sd_in    [ROOT_W];
    logic [REM_W-1:0]  rem_next [ROOT_W];
    logic [ROOT_W-1:0] root_next[ROOT_W];

    always_comb
    begin
        rem_in[0]  = '0;
        root_in[0] = '0;
        x_in[0]    = rad;
        sd_in[0]   = side_in;
        for (int k = 1; k < ROOT_W; k++)
        begin
            rem_in[k]  = rem_reg[k-1];
            root_in[k] = root_reg[k-1];
            x_in[k]    = x_reg[k-1];
            sd_in[k]   = side_reg[k-1];
        end
    end

    always_comb
    begin
        logic [REM_W-1:0] rem_s;
        logic [REM_W-1:0] trial;
        for (int k = 0; k < ROOT_W; k++)
        begin
            rem_s = {rem_in[k][REM_W-3:0], x_in[k][RAD_W-1 -: 2]};
            trial = REM_W'({root_in[k], 2'b01});
            if (rem_s >= trial)
            begin
                rem_next[k]  = rem_s - trial;
                root_next[k] = {root_in[k][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = rem_s;
                root_next[k] = {root_in[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < ROOT_W; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                x_reg[k]    <= x_in[k] << 2;
                side_reg[k] <= sd_in[k];
            end
        end
    end

    assign root     = root_reg[ROOT_W-1];
    assign side_out = side_reg[ROOT_W-1];

endmodule

`default_nettype wire

>>> rtl/core/pis_div.sv
// One root lane: sign check, saturation test, then a restoring divide, one bit per stage.
// Gives floor((|num| << FRAC_BITS) / |den|) saturated, or zero when not positive or the lane is unused.
`default_nettype none

module pis_div
    import pis_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic                    use_lane,
    input  wire logic signed [NUM_W:0]   num,
    input  wire logic signed [DEN_W:0]   den,
    output logic [Q_W-1:0]               t
);

    localparam int X_W = NUM_W + FRAC_BITS;
    localparam int W_W = NUM_W + Q_W;

    logic [NUM_W-1:0] nmag_reg;
    logic [DEN_W-1:0] dmag0_reg;
    logic             pos0_reg;

    logic [DEN_W:0]   r_reg   [Q_W+1];
    logic [Q_W-1:0]   lo_reg  [Q_W+1];
    logic [Q_W-1:0]   q_reg   [Q_W+1];
    logic [DEN_W-1:0] dm_reg  [Q_W+1];
    logic             pos_reg [Q_W+1];
    logic             sat_reg [Q_W+1];

    logic [X_W-1:0]   x_init;
    logic [DEN_W:0]   r_next  [Q_W+1];
    logic [Q_W-1:0]   q_next  [Q_W+1];

    assign x_init = {nmag_reg, {FRAC_BITS{1'b0}}};

    always_comb
    begin
        logic [DEN_W:0] rs;
        r_next[0] = (DEN_W + 1)'(x_init >> Q_W);
        q_next[0] = '0;
        for (int k = 1; k <= Q_W; k++)
        begin
            rs = {r_reg[k-1][DEN_W-1:0], lo_reg[k-1][Q_W-1]};
            if (rs >= {1'b0, dm_reg[k-1]})
            begin
                r_next[k] = rs - {1'b0, dm_reg[k-1]};
                q_next[k] = {q_reg[k-1][Q_W-2:0], 1'b1};
            end
            else
            begin
                r_next[k] = rs;
                q_next[k] = {q_reg[k-1][Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nmag_reg  <= num[NUM_W] ? NUM_W'(-num) : NUM_W'(num);
            dmag0_reg <= den[DEN_W] ? DEN_W'(-den) : DEN_W'(den);
            pos0_reg  <= use_lane && (num != '0) && (den != '0) && (num[NUM_W] == den[DEN_W]);

            r_reg[0]   <= r_next[0];
            lo_reg[0]  <= x_init[Q_W-1:0];
            q_reg[0]   <= q_next[0];
            dm_reg[0]  <= dmag0_reg;
            pos_reg[0] <= pos0_reg;
            sat_reg[0] <= W_W'(nmag_reg) >= (W_W'(dmag0_reg) << (Q_W - FRAC_BITS));
            for (int k = 1; k <= Q_W; k++)
            begin
                r_reg[k]   <= r_next[k];
                lo_reg[k]  <= lo_reg[k-1] << 1;
                q_reg[k]   <= q_next[k];
                dm_reg[k]  <= dm_reg[k-1];
                pos_reg[k] <= pos_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
            end
        end
    end

    always_comb
    begin
        if (!pos_reg[Q_W])
        begin
            t = '0;
        end
        else if (sat_reg[Q_W])
        begin
            t = '1;
        end
        else
        begin
            t = q_reg[Q_W];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/pis_merge.sv
// Merge stage: pick the earliest valid root of the two lanes, then form the intercept point.
// Three register stages: select, multiply, shift-add with saturation. Uses pis_pkg.
`default_nettype none

module pis_merge
    import pis_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           en,
    input  wire logic [Q_W-1:0] t1,
    input  wire logic [Q_W-1:0] t2,
    input  wire side_t          side,
    output res_t                res
);

    localparam logic [Q_W-1:0] T_MIN = Q_W'(MIN_TIME_LSB);

    logic                    found0_reg, found1_reg;
    logic [Q_W-1:0]          t0_reg, t1_reg;
    side_t                   side0_reg;
    vec3_t                   tp1_reg;
    logic signed [PR_W-1:0]  prod_reg [3];
    res_t                    res_reg;

    logic [Q_W-1:0]          t_first, t_sel;
    logic                    found_next;
    res_t                    res_next;

    function automatic coord_t sat32(input logic signed [PR_W:0] v);
        if (v[PR_W:COORD_W-1] == '0 || v[PR_W:COORD_W-1] == '1)
        begin
            return coord_t'(v[COORD_W-1:0]);
        end
        return v[PR_W] ? coord_t'({1'b1, {(COORD_W-1){1'b0}}})
                       : coord_t'({1'b0, {(COORD_W-1){1'b1}}});
    endfunction

    always_comb
    begin
        t_first = (t1 > T_MIN) ? t1 : '0;
        if ((t2 > T_MIN) && ((t_first <= T_MIN) || (t2 < t_first)))
        begin
            t_sel = t2;
        end
        else
        begin
            t_sel = t_first;
        end
        found_next = side.spd_nz && (t_sel > T_MIN);
    end

    always_comb
    begin
        logic signed [PR_W:0] sum [3];
        for (int i = 0; i < 3; i++)
        begin
            sum[i] = (PR_W + 1)'($signed(tp1_reg[i])) + (PR_W + 1)'(prod_reg[i] >>> FRAC_BITS);
        end
        res_next.found = found1_reg;
        if (found1_reg)
        begin
            res_next.t = coord_t'({1'b0, t1_reg});
            res_next.x = sat32(sum[0]);
            res_next.y = sat32(sum[1]);
            res_next.z = sat32(sum[2]);
        end
        else
        begin
            res_next.t = FAIL_TIME;
            res_next.x = tp1_reg[0];
            res_next.y = tp1_reg[1];
            res_next.z = tp1_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            found0_reg <= found_next;
            t0_reg     <= t_sel;
            side0_reg  <= side;
            found1_reg <= found0_reg;
            t1_reg     <= t0_reg;
            tp1_reg    <= side0_reg.tp;
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= PR_W'($signed(side0_reg.tv[i])) * PR_W'($signed({1'b0, t0_reg}));
            end
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire
